// File: sv/longest_prefix_match_search_core_defines.svh
// Assertion macros used by the checker of the match search core.
`ifndef LONGEST_PREFIX_MATCH_SEARCH_CORE_DEFINES_SVH
`define LONGEST_PREFIX_MATCH_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LPMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpms assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LPMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpms assertion failed");

`endif

// File: sv/lpms_pkg.sv
`timescale 1ns / 1ps
package lpms_pkg;

  localparam logic [1:0] CMD_SRC    = 2'd0;
  localparam logic [1:0] CMD_TAR    = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam int LEN_W = 9;
  localparam int OFF_W = 12;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic       clr;    // drop the stored target byte
    logic       start;  // open a search: clear run flags, seed token
    logic       step;   // a source byte is on src this cycle
    logic [7:0] src;
  } lpms_ctrl_t;

endpackage

// File: sv/lpms_cell.sv
`timescale 1ns / 1ps
module lpms_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lpms_pkg::lpms_ctrl_t ctrl,
  input  logic                wr_sel,
  input  logic [7:0]          wr_byte,
  input  logic                alive_in,
  input  logic                hit_in,
  output logic                alive_out,
  output logic                hit_out
);
  import lpms_pkg::*;

  logic [7:0] tbyte_r;
  logic       valid_r;
  logic       alive_r;
  logic       token_r;
  logic       alive_nxt;

  // Prefix of length index+1 ends on the current source byte.
  assign alive_nxt = valid_r && (ctrl.src == tbyte_r) && (FIRST || alive_in);
  assign hit_out   = ctrl.step && token_r && alive_nxt;
  assign alive_out = alive_r;

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      tbyte_r <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      alive_r <= 1'b0;
      token_r <= 1'b0;
    end else begin
      if (ctrl.clr) begin
        valid_r <= 1'b0;
      end else if (wr_sel) begin
        valid_r <= 1'b1;
      end
      if (ctrl.start) begin
        alive_r <= 1'b0;
        token_r <= FIRST;
      end else if (ctrl.step) begin
        alive_r <= alive_nxt;
        token_r <= hit_in || (token_r && !alive_nxt);
      end
    end
  end

endmodule

// File: sv/longest_prefix_match_search_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | in_cmd[1:0], in_data_byte[7:0]
// out_    | output    | out_valid/out_stall| out_match_length[8:0], out_match_offset[11:0]
//
// Appends and clears are accepted back to back.
// During a search the source memory is read one byte per cycle through its
// single registered read port into the cell row.
// Reset (synchronous, rst_n low) empties both buffers; no clearing pass.
// A search is held off while an earlier result waits on out_stall.
module longest_prefix_match_search_core #(
  parameter int SRC_DEPTH = 4096,
  parameter int TAR_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic [7:0]                in_data_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lpms_pkg::LEN_W-1:0] out_match_length,
  output logic [lpms_pkg::OFF_W-1:0] out_match_offset
);
  import lpms_pkg::*;

  localparam int AW  = $clog2(SRC_DEPTH);
  localparam int SCW = $clog2(SRC_DEPTH + 1);
  localparam int TCW = $clog2(TAR_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic           state_r;
  logic [SCW-1:0] scount_r;
  logic [TCW-1:0] tcount_r;
  logic [SCW-1:0] rd_addr_r;
  logic           rd_vld_r;
  logic [AW-1:0]  pos_r;
  logic [7:0]     src_q_r;
  logic [TCW-1:0] best_len_r;
  logic [AW-1:0]  best_off_r;
  logic           out_valid_r;
  logic [LEN_W-1:0] out_len_r;
  logic [OFF_W-1:0] out_off_r;

  logic [7:0] src_mem [SRC_DEPTH];

  logic acc, src_wr, tar_wr, do_clear, do_search, issue, finish, any_hit;
  lpms_ctrl_t ctrl;
  logic [TAR_DEPTH-1:0] wr_sel, alive, hit;

  // Hold intake while a search runs; hold a new search while a result waits.
  assign in_stall  = (state_r == ST_RUN) || (out_valid_r && in_cmd == CMD_SEARCH);
  assign acc       = in_valid && !in_stall;
  assign src_wr    = acc && in_cmd == CMD_SRC && scount_r < SCW'(SRC_DEPTH);
  assign tar_wr    = acc && in_cmd == CMD_TAR && tcount_r < TCW'(TAR_DEPTH);
  assign do_clear  = acc && in_cmd == CMD_CLEAR;
  assign do_search = acc && in_cmd == CMD_SEARCH;
  assign issue     = (state_r == ST_RUN) && rd_addr_r < scount_r;
  assign finish    = (state_r == ST_RUN) && !issue && !rd_vld_r;
  assign any_hit   = |hit;

  assign ctrl.clr   = do_clear || finish;
  assign ctrl.start = do_search;
  assign ctrl.step  = rd_vld_r;
  assign ctrl.src   = src_q_r;

  // Row of cells: cell k holds target byte k and the run flag for length k+1.
  // The token marks the cell whose hit would extend the best length.
  for (genvar k = 0; k < TAR_DEPTH; k++) begin : g_cell
    assign wr_sel[k] = tar_wr && tcount_r == TCW'(k);
    if (k == 0) begin : g_first
      lpms_cell #(.FIRST(1'b1)) u_cell (
        .clk, .rst_n, .ctrl, .wr_sel(wr_sel[k]), .wr_byte(in_data_byte),
        .alive_in(1'b0), .hit_in(1'b0), .alive_out(alive[k]), .hit_out(hit[k])
      );
    end else begin : g_rest
      lpms_cell #(.FIRST(1'b0)) u_cell (
        .clk, .rst_n, .ctrl, .wr_sel(wr_sel[k]), .wr_byte(in_data_byte),
        .alive_in(alive[k-1]), .hit_in(hit[k-1]), .alive_out(alive[k]),
        .hit_out(hit[k])
      );
    end
  end

  // Source memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (src_wr) begin
      src_mem[scount_r[AW-1:0]] <= in_data_byte;
    end
    if (issue) begin
      src_q_r <= src_mem[rd_addr_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pos_r <= rd_addr_r[AW-1:0];
    end
    if (do_search) begin
      best_off_r <= '0;
    end else if (rd_vld_r && any_hit) begin
      // New best starts best_len bytes before this one, earliest by scan order.
      best_off_r <= pos_r - AW'(best_len_r);
    end
    if (finish) begin
      out_len_r <= LEN_W'(best_len_r);
      out_off_r <= OFF_W'(best_off_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scount_r    <= '0;
      tcount_r    <= '0;
      rd_addr_r   <= '0;
      rd_vld_r    <= 1'b0;
      best_len_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (issue) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      if (do_search) begin
        state_r    <= ST_RUN;
        rd_addr_r  <= '0;
        best_len_r <= '0;
      end else if (rd_vld_r && any_hit) begin
        best_len_r <= best_len_r + 1'b1;
      end
      if (finish) begin
        state_r  <= ST_IDLE;
        tcount_r <= '0;
      end
      if (src_wr) begin
        scount_r <= scount_r + 1'b1;
      end
      if (tar_wr) begin
        tcount_r <= tcount_r + 1'b1;
      end
      if (do_clear) begin
        scount_r <= '0;
        tcount_r <= '0;
      end
      // Advance the result on transfer, raise it when a search ends.
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_match_length = out_len_r;
  assign out_match_offset = out_off_r;

endmodule

// File: sv/lpms_checker.sv
`timescale 1ns / 1ps
`include "longest_prefix_match_search_core_defines.svh"
module lpms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_stall,
  input logic [8:0]  out_match_length,
  input logic [11:0] out_match_offset
);
  import lpms_pkg::*;

  `LPMS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_match_length) && $stable(out_match_offset))
  `LPMS_ASSERT_IMP(a_len_range, out_valid, out_match_length <= 9'd256)
  `LPMS_ASSERT_NXT(a_search_busy, in_valid && !in_stall && in_cmd == CMD_SEARCH, in_stall)
  `LPMS_ASSERT_IMP(a_result_after_run, $rose(out_valid), $past(in_stall))

endmodule

bind longest_prefix_match_search_core lpms_checker u_lpms_checker (.*);

// File: bench/lpms_search_checker.sv
`timescale 1ns / 1ps
module lpms_search_checker #(
  parameter int SRC_DEPTH = 4096,
  parameter int TAR_DEPTH = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_cmd,
  input  logic [7:0]                  in_data_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [lpms_pkg::LEN_W-1:0]  out_match_length,
  input  logic [lpms_pkg::OFF_W-1:0]  out_match_offset,
  output int                          fail_count,
  output int                          pending_count,
  output int                          search_count,
  output int                          hit_count
);
  import lpms_pkg::*;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [OFF_W-1:0] offset;
  } match_t;

  logic [7:0] src_bytes [SRC_DEPTH];
  logic [7:0] tar_bytes [TAR_DEPTH];
  int         src_fill;
  int         tar_fill;
  match_t     pending_matches [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Walk start offsets in order until no longer run is possible; keep the first one reaching the longest run.
  function automatic match_t find_longest();
    match_t best;
    int     run;
    best = '0;
    if (src_fill == 0 || tar_fill == 0) return best;
    for (int p = 0; p < src_fill && int'(best.length) < tar_fill; p++) begin
      if (p + int'(best.length) >= src_fill) break;
      run = 0;
      while (p + run < src_fill && run < tar_fill && src_bytes[p + run] == tar_bytes[run])
        run++;
      if (run > int'(best.length)) begin
        best.length = run[LEN_W-1:0];
        best.offset = p[OFF_W-1:0];
      end
    end
    return best;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
    search_count = 0;
    hit_count = 0;
    src_fill = 0;
    tar_fill = 0;
  end

  always @(posedge clk) begin
    match_t got;
    match_t want;
    if (!rst_n) begin
      src_fill = 0;
      tar_fill = 0;
    end else begin
      if (in_valid && !in_stall) begin
        case (in_cmd)
          CMD_SRC: if (src_fill < SRC_DEPTH) src_bytes[src_fill++] = in_data_byte;
          CMD_TAR: if (tar_fill < TAR_DEPTH) tar_bytes[tar_fill++] = in_data_byte;
          CMD_CLEAR: begin
            src_fill = 0;
            tar_fill = 0;
          end
          default: begin
            want = find_longest();
            pending_matches.push_back(want);
            tar_fill = 0;
            search_count++;
            if (want.length != 0) hit_count++;
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        got.length = out_match_length;
        got.offset = out_match_offset;
        if (pending_matches.size() == 0) begin
          report_mismatch("result with no search outstanding");
        end else begin
          want = pending_matches.pop_front();
          if (got.length !== want.length)
            report_mismatch($sformatf("length got %0d want %0d", got.length, want.length));
          if (got.offset !== want.offset)
            report_mismatch($sformatf("offset got %0d want %0d", got.offset, want.offset));
        end
      end
      pending_count = pending_matches.size();
    end
  end
endmodule

// File: bench/tb_longest_prefix_match_search_core.sv
`timescale 1ns / 1ps
module tb_longest_prefix_match_search_core;
  import lpms_pkg::*;

  localparam int SRC_DEPTH   = 64;
  localparam int TAR_DEPTH   = 16;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_cmd = CMD_SRC;
  logic [7:0]       in_data_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [LEN_W-1:0] out_match_length;
  logic [OFF_W-1:0] out_match_offset;

  int  fail_count, pending_count, search_count, hit_count;
  int  cycle_count = 0;
  int  item_count = 0;
  int  full_hits = 0;
  logic [7:0] src_shadow [$];

  always #5 clk = ~clk;

  longest_prefix_match_search_core #(
    .SRC_DEPTH(SRC_DEPTH),
    .TAR_DEPTH(TAR_DEPTH)
  ) u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_data_byte,
    .out_valid, .out_stall, .out_match_length, .out_match_offset
  );

  lpms_search_checker #(
    .SRC_DEPTH(SRC_DEPTH),
    .TAR_DEPTH(TAR_DEPTH)
  ) u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_data_byte,
    .out_valid, .out_stall, .out_match_length, .out_match_offset,
    .fail_count, .pending_count, .search_count, .hit_count
  );

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** longest_prefix_match_search_core: FAILED **");
      $finish;
    end
  end

  // Receiver stalls in its own rhythm: calm stretches, then choppy ones.
  always @(posedge clk) begin
    if (((cycle_count / 500) % 3) == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 40);
  end

  // Drive one transfer and hold it until accepted. A random gap between
  // bursts drops valid; back-to-back items keep valid high across edges.
  int burst_left = 0;
  task automatic send(input logic [1:0] cmd, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
    if (cmd == CMD_SRC && src_shadow.size() < SRC_DEPTH) src_shadow.push_back(data);
    if (cmd == CMD_CLEAR) src_shadow.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Push a target: mostly a slice of the current source, possibly mutated.
  task automatic send_target(input int len);
    int start;
    bit from_src;
    from_src = src_shadow.size() > 0 && $urandom_range(0, 99) < 75;
    start = from_src ? $urandom_range(0, src_shadow.size() - 1) : 0;
    for (int k = 0; k < len; k++) begin
      if (from_src && start + k < src_shadow.size() && $urandom_range(0, 19) != 0)
        send(CMD_TAR, src_shadow[start + k]);
      else
        send(CMD_TAR, 8'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: search on empty buffers, then on an empty source, then on an empty target.
    send(CMD_SEARCH, 8'hFF);
    send(CMD_TAR, 8'h00);
    send(CMD_SEARCH, 8'h00);
    send(CMD_SRC, 8'h00);
    send(CMD_SRC, 8'hFF);
    send(CMD_SEARCH, 8'h55);
    // Ties: pattern AB AB, target AB picks lowest offset; no-match case.
    send(CMD_SRC, 8'hAA);
    send(CMD_SRC, 8'h55);
    send(CMD_SRC, 8'hAA);
    send(CMD_SRC, 8'h55);
    send(CMD_TAR, 8'hAA);
    send(CMD_TAR, 8'h55);
    send(CMD_SEARCH, 8'h00);
    send(CMD_TAR, 8'h12);
    send(CMD_SEARCH, 8'h00);
    // Match would run past source end.
    send(CMD_TAR, 8'h55);
    send(CMD_TAR, 8'h77);
    send(CMD_SEARCH, 8'h00);
    send(CMD_CLEAR, 8'hFF);
    send(CMD_TAR, 8'h00);
    send(CMD_SEARCH, 8'h00);
    drain();

    // Full buffers: fill target past capacity, then source past capacity.
    send(CMD_SRC, 8'h01);
    for (int k = 0; k < TAR_DEPTH + 3; k++) send(CMD_TAR, 8'h01);
    send(CMD_SEARCH, 8'h00);
    drain();
    send(CMD_CLEAR, 8'h00);
    for (int k = 0; k < SRC_DEPTH + 3; k++) send(CMD_SRC, 8'($urandom_range(0, 255)));
    for (int k = 0; k < TAR_DEPTH; k++) send(CMD_TAR, src_shadow[SRC_DEPTH - TAR_DEPTH + k]);
    send(CMD_SEARCH, 8'h00);
    send(CMD_TAR, src_shadow[SRC_DEPTH - 1]);
    send(CMD_SEARCH, 8'h00);
    send(CMD_CLEAR, 8'h00);
    drain();
    full_hits = hit_count;

    // Random: small sources over a tiny alphabet, targets cut from them.
    for (int round = 0; item_count < 650 && round < 60; round++) begin
      if ($urandom_range(0, 3) == 0) send(CMD_CLEAR, 8'($urandom_range(0, 255)));
      n = $urandom_range(0, 6);
      for (int k = 0; k < n; k++)
        send(CMD_SRC, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 3)));
      send_target($urandom_range(0, 6));
      if ($urandom_range(0, 9) == 0) send(CMD_SRC, 8'($urandom_range(0, 255)));
      send(CMD_SEARCH, 8'($urandom_range(0, 255)));
      if (round == 30) drain();
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d transfers, %0d searches, %0d with a match",
             item_count, search_count, hit_count);
    $display("%0d of those matches came from the directed and buffer-limit checks",
             full_hits);
    if (fail_count == 0)
      $display("** longest_prefix_match_search_core: PASSED **");
    else
      $display("** longest_prefix_match_search_core: FAILED **");
    $finish;
  end
endmodule
